/* hdl/wpe_pkg.sv */
// Shared types, constants and helpers for the pixel line encoder.
package wpe_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned ShortW   = 12;
    localparam int unsigned CyclesW  = 16;
    localparam int unsigned BitsW    = 24;
    localparam int unsigned CntW     = 5;
    localparam int unsigned QDepth   = 2;
    localparam int unsigned QPtrW    = 1;
    localparam int unsigned QCntW    = 2;

    localparam logic [CntW-1:0] PixelBits = CntW'(24);
    localparam logic [CntW-1:0] ByteBits  = CntW'(8);

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LATCH     = 3'd4;

    localparam logic [ShortW-1:0]  RstZeroHigh = 12'd40;
    localparam logic [ShortW-1:0]  RstZeroLow  = 12'd85;
    localparam logic [ShortW-1:0]  RstOneHigh  = 12'd80;
    localparam logic [ShortW-1:0]  RstOneLow   = 12'd45;
    localparam logic [CyclesW-1:0] RstLatch    = 16'd5000;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_LATCH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic [ShortW-1:0]  zero_high;
        logic [ShortW-1:0]  zero_low;
        logic [ShortW-1:0]  one_high;
        logic [ShortW-1:0]  one_low;
        logic [CyclesW-1:0] latch;
    } t_cfg;

    // one queued job: kind plus bits, MSB first
    typedef struct packed {
        t_req             kind;
        logic [BitsW-1:0] bits;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [CyclesW-1:0] min1_short(input logic [ShortW-1:0] v);
        min1_short = (v == '0) ? CyclesW'(1) : {{(CyclesW-ShortW){1'b0}}, v};
    endfunction

    function automatic logic [CyclesW-1:0] min1_long(input logic [CyclesW-1:0] v);
        min1_long = (v == '0) ? CyclesW'(1) : v;
    endfunction

endpackage

/* hdl/ws2812_pixel_line_encoder_core.sv */
// Top level of the pixel line encoder: config registers, front end, queue, back end.
//
// Input channel (i_valid / o_stall) takes one request word: pixel, single
// byte or latch; request code 3 is accepted and dropped. Output channel
// (o_valid / i_stall) gives one line segment per word: level, duration in
// clock cycles, and a flag on the last segment of the request.
// A pixel gives 48 segments, a byte 16, a latch 1. The segment generator
// emits one segment per cycle while i_stall is low, and so sets the sustained
// input rate. An accepted word passes through the front register and the queue
// before the generator registers its first segment on the port.
// A two-entry job queue plus the front register let up to three requests
// wait while the generator is busy; o_stall rises once they are all taken.
// When i_stall is high while a segment is valid, it holds and the generator pauses.
// Reset (synchronous, active low) empties the queue, drops pending segments
// and loads the duration registers with their defaults. Durations of 0 are
// sent as 1. Write config (i_cfg_we / i_cfg_index / i_cfg_data) only while idle.
module ws2812_pixel_line_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wpe_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [wpe_pkg::CfgDataW-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_single_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_line_level,
    output logic [wpe_pkg::CyclesW-1:0]     o_segment_cycles,
    output logic                            o_last_segment
);

    wpe_pkg::t_cfg   r_cfg, n_cfg;
    wpe_pkg::t_job   f_job;
    wpe_pkg::t_job   q_head;
    wpe_pkg::t_qstat q_stat;
    logic            f_push;
    logic            f_held;
    logic            b_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                wpe_pkg::CFG_ZERO_HIGH: n_cfg.zero_high = i_cfg_data[wpe_pkg::ShortW-1:0];
                wpe_pkg::CFG_ZERO_LOW:  n_cfg.zero_low  = i_cfg_data[wpe_pkg::ShortW-1:0];
                wpe_pkg::CFG_ONE_HIGH:  n_cfg.one_high  = i_cfg_data[wpe_pkg::ShortW-1:0];
                wpe_pkg::CFG_ONE_LOW:   n_cfg.one_low   = i_cfg_data[wpe_pkg::ShortW-1:0];
                wpe_pkg::CFG_LATCH:     n_cfg.latch     = i_cfg_data;
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_high <= wpe_pkg::RstZeroHigh;
            r_cfg.zero_low  <= wpe_pkg::RstZeroLow;
            r_cfg.one_high  <= wpe_pkg::RstOneHigh;
            r_cfg.one_low   <= wpe_pkg::RstOneLow;
            r_cfg.latch     <= wpe_pkg::RstLatch;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    wpe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_single_byte (i_single_byte),
        .i_q_full      (q_stat.full),
        .o_push        (f_push),
        .o_held        (f_held),
        .o_job         (f_job)
    );

    wpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (b_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    wpe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head           (q_head),
        .i_qstat          (q_stat),
        .o_pop            (b_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_line_level     (o_line_level),
        .o_segment_cycles (o_segment_cycles),
        .o_last_segment   (o_last_segment)
    );

    a_no_zero_duration: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_segment_cycles != '0)
        else $error("segment of zero duration");

    a_last_is_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_level |-> !o_last_segment)
        else $error("run ends on a high segment");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty) && !(b_pop && q_stat.empty))
        else $error("queue flags or pop inconsistent");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> f_held && q_stat.full)
        else $error("input stalled with room in front end");

endmodule

/* hdl/wpe_front.sv */
// Front end: takes request words, drops unused codes, packs jobs for the queue.
module wpe_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    input  logic [7:0]               i_single_byte,
    input  logic                     i_q_full,
    output logic                     o_push,
    output logic                     o_held,
    output wpe_pkg::t_job            o_job
);

    logic          r_valid, n_valid;
    wpe_pkg::t_job r_job, n_job;
    wpe_pkg::t_req req;
    logic          accept;

    assign req     = wpe_pkg::t_req'(i_req_type);
    assign o_stall = r_valid & i_q_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_q_full;
    assign o_held  = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid & ~o_push;
        n_job   = r_job;
        if (accept && req != wpe_pkg::REQ_NONE) begin
            n_valid   = 1'b1;
            n_job.kind = req;
            unique case (req)
                wpe_pkg::REQ_PIXEL: n_job.bits = {i_green, i_red, i_blue};
                wpe_pkg::REQ_BYTE:  n_job.bits = {i_single_byte, 16'h0000};
                wpe_pkg::REQ_LATCH: n_job.bits = '0;
                default:            n_job.bits = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

/* hdl/wpe_queue.sv */
// Two-entry job queue between front end and segment generator.
module wpe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wpe_pkg::t_job   i_job,
    input  logic            i_pop,
    output wpe_pkg::t_job   o_head,
    output wpe_pkg::t_qstat o_stat
);

    wpe_pkg::t_job                r_mem [wpe_pkg::QDepth];
    logic [wpe_pkg::QPtrW-1:0]    r_wr, n_wr;
    logic [wpe_pkg::QPtrW-1:0]    r_rd, n_rd;
    logic [wpe_pkg::QCntW-1:0]    r_cnt, n_cnt;

    function automatic logic [wpe_pkg::QPtrW-1:0] QPtrOne(input logic b);
        QPtrOne = wpe_pkg::QPtrW'(b);
    endfunction

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == wpe_pkg::QCntW'(wpe_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr + QPtrOne(i_push);
        n_rd  = r_rd + QPtrOne(i_pop);
        n_cnt = r_cnt + wpe_pkg::QCntW'(i_push) - wpe_pkg::QCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* hdl/wpe_back.sv */
// Back end: expands queued jobs into line segments, one per cycle unless the output stalls.
module wpe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wpe_pkg::t_cfg                 i_cfg,
    input  wpe_pkg::t_job                 i_head,
    input  wpe_pkg::t_qstat               i_qstat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_line_level,
    output logic [wpe_pkg::CyclesW-1:0]   o_segment_cycles,
    output logic                          o_last_segment
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_HIGH = 3'b010,
        ST_LOW  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [wpe_pkg::BitsW-1:0]     r_bits, n_bits;
    logic [wpe_pkg::CntW-1:0]      r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          r_level, n_level;
    logic [wpe_pkg::CyclesW-1:0]   r_cycles, n_cycles;
    logic                          r_last, n_last;
    logic                          advance;
    logic                          seg_last;

    assign advance          = ~r_out_valid | ~i_stall;
    assign seg_last         = (r_cnt == wpe_pkg::CntW'(1));
    assign o_valid          = r_out_valid;
    assign o_line_level     = r_level;
    assign o_segment_cycles = r_cycles;
    assign o_last_segment   = r_last;

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_level     = r_level;
        n_cycles    = r_cycles;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (advance) begin
            n_out_valid = 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        if (i_head.kind == wpe_pkg::REQ_LATCH) begin
                            n_level  = 1'b0;
                            n_cycles = wpe_pkg::min1_long(i_cfg.latch);
                            n_last   = 1'b1;
                        end else begin
                            // first high segment goes out while the job loads
                            n_level  = 1'b1;
                            n_cycles = wpe_pkg::min1_short(i_head.bits[wpe_pkg::BitsW-1] ?
                                                           i_cfg.one_high : i_cfg.zero_high);
                            n_last   = 1'b0;
                            n_bits   = i_head.bits;
                            n_cnt    = (i_head.kind == wpe_pkg::REQ_PIXEL) ?
                                       wpe_pkg::PixelBits : wpe_pkg::ByteBits;
                            n_state  = ST_LOW;
                        end
                    end
                end
                ST_HIGH: begin
                    n_out_valid = 1'b1;
                    n_level     = 1'b1;
                    n_cycles    = wpe_pkg::min1_short(r_bits[wpe_pkg::BitsW-1] ?
                                                      i_cfg.one_high : i_cfg.zero_high);
                    n_last      = 1'b0;
                    n_state     = ST_LOW;
                end
                ST_LOW: begin
                    n_out_valid = 1'b1;
                    n_level     = 1'b0;
                    n_cycles    = wpe_pkg::min1_short(r_bits[wpe_pkg::BitsW-1] ?
                                                      i_cfg.one_low : i_cfg.zero_low);
                    n_last      = seg_last;
                    n_bits      = {r_bits[wpe_pkg::BitsW-2:0], 1'b0};
                    n_cnt       = r_cnt - wpe_pkg::CntW'(1);
                    n_state     = seg_last ? ST_IDLE : ST_HIGH;
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bits   <= n_bits;
        r_cnt    <= n_cnt;
        r_level  <= n_level;
        r_cycles <= n_cycles;
        r_last   <= n_last;
    end

endmodule

/* bench/ws2812_pixel_line_encoder_core_tb.sv */
// Self-checking testbench for the pixel line encoder: request words in, line segments checked out.
module ws2812_pixel_line_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT    = 8;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_WORDS = 50;

    // indexes past the last register; writes there must be dropped
    localparam logic [wpe_pkg::CfgIdxW-1:0] CFG_UNUSED_A = 3'd5;
    localparam logic [wpe_pkg::CfgIdxW-1:0] CFG_UNUSED_B = 3'd6;
    localparam logic [wpe_pkg::CfgIdxW-1:0] CFG_UNUSED_C = 3'd7;

    typedef struct packed {
        logic                        level;
        logic [wpe_pkg::CyclesW-1:0] cycles;
        logic                        last;
    } t_line_seg;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [wpe_pkg::CfgIdxW-1:0]   i_cfg_index   = '0;
    logic [wpe_pkg::CfgDataW-1:0]  i_cfg_data    = '0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_req_type    = '0;
    logic [7:0]                    i_red         = '0;
    logic [7:0]                    i_green       = '0;
    logic [7:0]                    i_blue        = '0;
    logic [7:0]                    i_single_byte = '0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic                          o_line_level;
    logic [wpe_pkg::CyclesW-1:0]   o_segment_cycles;
    logic                          o_last_segment;

    wpe_pkg::t_cfg cfg_shadow;
    t_line_seg     pending_segs[$];
    int unsigned   mismatches  = 0;
    int unsigned   seg_count   = 0;
    int unsigned   idle_cycles = 0;
    bit            quiet       = 1'b0;
    int unsigned   hold_asks   = 0;
    int unsigned   hold_seen   = 0;
    int unsigned   hold_left   = 0;

    ws2812_pixel_line_encoder_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_single_byte    (i_single_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_line_level     (o_line_level),
        .o_segment_cycles (o_segment_cycles),
        .o_last_segment   (o_last_segment)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // inputs only move at the rising edge, so the falling edge sees settled handshakes
    always @(negedge i_clk) begin
        t_line_seg got;
        t_line_seg want;
        got = '{level: o_line_level, cycles: o_segment_cycles, last: o_last_segment};
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_segs.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("segment %0d: none expected, got level %0b cycles %0d last %0b",
                             seg_count, got.level, got.cycles, got.last);
            end else begin
                want = pending_segs.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("segment %0d: expected level %0b cycles %0d last %0b, ",
                                 seg_count, want.level, want.cycles, want.last,
                                 "got level %0b cycles %0d last %0b",
                                 got.level, got.cycles, got.last);
                end
            end
            seg_count <= seg_count + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [wpe_pkg::CyclesW-1:0] nonzero_cycles(
        input logic [wpe_pkg::CyclesW-1:0] v);
        return (v == '0) ? wpe_pkg::CyclesW'(1) : v;
    endfunction

    // segments one request should produce under the current register values
    task automatic expect_segments(input wpe_pkg::t_req kind,
                                   input logic [7:0] red, green, blue,
                                   input logic [7:0] sbyte);
        logic [23:0] bits;
        int          nbits;
        logic        b;
        case (kind)
            wpe_pkg::REQ_PIXEL: begin
                bits  = {green, red, blue};
                nbits = 24;
            end
            wpe_pkg::REQ_BYTE: begin
                bits  = {sbyte, 16'h0000};
                nbits = 8;
            end
            wpe_pkg::REQ_LATCH: begin
                pending_segs.push_back('{level: 1'b0,
                                         cycles: nonzero_cycles(cfg_shadow.latch),
                                         last: 1'b1});
                return;
            end
            default: return;
        endcase
        for (int i = 0; i < nbits; i++) begin
            b = bits[23-i];
            pending_segs.push_back('{level: 1'b1,
                cycles: nonzero_cycles(wpe_pkg::CyclesW'(
                    b ? cfg_shadow.one_high : cfg_shadow.zero_high)),
                last: 1'b0});
            pending_segs.push_back('{level: 1'b0,
                cycles: nonzero_cycles(wpe_pkg::CyclesW'(
                    b ? cfg_shadow.one_low : cfg_shadow.zero_low)),
                last: (i == nbits - 1)});
        end
    endtask

    task automatic send_word(input wpe_pkg::t_req kind, input logic [7:0] red, green, blue,
                             input logic [7:0] sbyte);
        logic taken;
        if (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= kind;
        i_red         <= red;
        i_green       <= green;
        i_blue        <= blue;
        i_single_byte <= sbyte;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        expect_segments(kind, red, green, blue, sbyte);
    endtask

    task automatic send_random(input wpe_pkg::t_req kind);
        send_word(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // request code 3 leaves no segment behind, so allow the pipeline to empty too
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wpe_pkg::CfgIdxW-1:0] idx,
                             input logic [wpe_pkg::CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            wpe_pkg::CFG_ZERO_HIGH: cfg_shadow.zero_high = data[wpe_pkg::ShortW-1:0];
            wpe_pkg::CFG_ZERO_LOW:  cfg_shadow.zero_low  = data[wpe_pkg::ShortW-1:0];
            wpe_pkg::CFG_ONE_HIGH:  cfg_shadow.one_high  = data[wpe_pkg::ShortW-1:0];
            wpe_pkg::CFG_ONE_LOW:   cfg_shadow.one_low   = data[wpe_pkg::ShortW-1:0];
            wpe_pkg::CFG_LATCH:     cfg_shadow.latch     = data;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [wpe_pkg::CfgDataW-1:0] zh, zl, oh, ol, lat,
                               input logic [wpe_pkg::CfgIdxW-1:0] spare_idx);
        write_reg(wpe_pkg::CFG_ZERO_HIGH, zh);
        write_reg(wpe_pkg::CFG_ZERO_LOW, zl);
        write_reg(wpe_pkg::CFG_ONE_HIGH, oh);
        write_reg(wpe_pkg::CFG_ONE_LOW, ol);
        write_reg(wpe_pkg::CFG_LATCH, lat);
        write_reg(spare_idx, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // upper nibble is junk on purpose: only the low 12 bits may land
    function automatic logic [wpe_pkg::CfgDataW-1:0] rand_short_word();
        logic [wpe_pkg::ShortW-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = wpe_pkg::ShortW'(1);
            default: v = wpe_pkg::ShortW'($urandom_range(1, 300));
        endcase
        return {4'($urandom), v};
    endfunction

    function automatic logic [wpe_pkg::CfgDataW-1:0] rand_latch_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return wpe_pkg::CfgDataW'(1);
            default: return wpe_pkg::CfgDataW'($urandom);
        endcase
    endfunction

    task automatic test_default_timing();
        send_word(wpe_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'($urandom));
        send_word(wpe_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'($urandom));
        send_word(wpe_pkg::REQ_PIXEL, 8'hA5, 8'h5A, 8'h0F, 8'($urandom));
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h00);
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'hFF);
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h80);
        send_random(wpe_pkg::REQ_LATCH);
        send_random(wpe_pkg::REQ_NONE);
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h01);
        send_random(wpe_pkg::REQ_LATCH);
        send_random(wpe_pkg::REQ_PIXEL);
    endtask

    task automatic test_duration_extremes();
        // all-ones data: shorts clip to 4095, latch at its top
        wait_idle();
        load_config('1, '1, '1, '1, '1, CFG_UNUSED_A);
        send_word(wpe_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'hAA, 8'($urandom));
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h3C);
        send_random(wpe_pkg::REQ_LATCH);
        // zero durations go out with a duration value of 1
        wait_idle();
        load_config('0, '0, '0, '0, '0, CFG_UNUSED_B);
        send_random(wpe_pkg::REQ_PIXEL);
        send_word(wpe_pkg::REQ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'h81);
        send_random(wpe_pkg::REQ_LATCH);
        wait_idle();
        load_config(16'hF001, 16'hA002, 16'h5003, 16'h0FFE, 16'd1, CFG_UNUSED_C);
        send_random(wpe_pkg::REQ_PIXEL);
        send_random(wpe_pkg::REQ_LATCH);
    endtask

    // receiver freezes while the sender keeps pushing, so the front end must stall
    task automatic test_output_holdoff();
        wait_idle();
        quiet = 1'b1;
        hold_asks++;
        for (int i = 0; i < 10; i++) send_random(wpe_pkg::REQ_BYTE);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [wpe_pkg::CfgIdxW-1:0] unused_idx[3];
        int unsigned                 counted;
        int unsigned                 pick;
        unused_idx = '{CFG_UNUSED_A, CFG_UNUSED_B, CFG_UNUSED_C};
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            load_config(rand_short_word(), rand_short_word(), rand_short_word(),
                        rand_short_word(), rand_latch_word(), unused_idx[$urandom_range(2)]);
            quiet   = (p == 3);
            counted = 0;
            while (counted < PHASE_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    send_random(wpe_pkg::REQ_PIXEL);
                    counted++;
                end else if (pick < 75) begin
                    send_random(wpe_pkg::REQ_BYTE);
                    counted++;
                end else if (pick < 92) begin
                    send_random(wpe_pkg::REQ_LATCH);
                    counted++;
                end else begin
                    send_random(wpe_pkg::REQ_NONE);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        cfg_shadow = '{zero_high: wpe_pkg::RstZeroHigh, zero_low: wpe_pkg::RstZeroLow,
                       one_high: wpe_pkg::RstOneHigh, one_low: wpe_pkg::RstOneLow,
                       latch: wpe_pkg::RstLatch};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_timing();
        test_duration_extremes();
        test_output_holdoff();
        test_random_traffic();
        wait_idle();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_segs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
hdl/wpe_pkg.sv
hdl/wpe_front.sv
hdl/wpe_queue.sv
hdl/wpe_back.sv
hdl/ws2812_pixel_line_encoder_core.sv
bench/ws2812_pixel_line_encoder_core_tb.sv
